// ===== hdl/msh_pkg.sv =====
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants for the multi-mode string hash
// Mode codes, transaction payloads and the running hash state.
// ----------------------------------------------------------------------------
package msh_pkg;

    localparam int HASH_W          = 32;
    localparam int BUCKET_W        = 10;
    localparam int BUCKETS_DEFAULT = 1024;

    typedef enum logic [2:0] {
        MODE_ZERO    = 3'd0,
        MODE_LENGTH  = 3'd1,
        MODE_FIRST   = 3'd2,
        MODE_SUM     = 3'd3,
        MODE_DJB2    = 3'd4,
        MODE_ROTXOR  = 3'd5,
        MODE_CRC32   = 3'd6,
        MODE_CRC32C  = 3'd7
    } mode_t;

    localparam mode_t MODE_RESET = MODE_CRC32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0]   hash_value;
        logic [BUCKET_W-1:0] bucket_index;
    } out_item_t;

    // State carried from one byte of a string to the next
    typedef struct packed {
        logic [HASH_W-1:0] running_hash;
        logic [31:0]       byte_count;
        logic [7:0]        first_char;
    } msh_state_t;

endpackage

// ===== hdl/multi_mode_string_hash.sv =====
// ----------------------------------------------------------------------------
// multi_mode_string_hash: byte-stream string hasher with eight modes
// Zero, length, first byte, sum, djb2, rotate-xor, CRC-32 and CRC-32C.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload            | direction
//   --------+----------------------+--------------------+----------
//   in      | in_valid / in_stall  | in_data (in_item_t)  | in
//   out     | out_valid / out_stall| out_data (out_item_t)| out
//   cfg     | cfg_valid / cfg_ready| cfg_data (hash_mode) | in
//
// One byte transaction per cycle while in_stall is low. The byte update (CRC, djb2 and the rest)
// sits between the state register and itself, so strings stream without gaps.
// A last byte passes hash register, reciprocal product and remainder into the
// output register, whose valid bit drives out_valid. in_stall rises only when
// all three result stages hold data and out_stall is high. Reset clears the
// string state (CRC-32 start value) and mode = CRC-32.
//
module multi_mode_string_hash #(
    parameter int BUCKETS = msh_pkg::BUCKETS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msh_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output msh_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_data
);
    import msh_pkg::*;

    mode_t              mode_reg;
    msh_state_t         state_reg;
    msh_state_t         state_next;
    logic [HASH_W-1:0]  hash_fin;
    logic               hash_stall;
    logic               in_accept;

    // Config is to be written only while idle; the block does not enforce it. Always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RESET;
        else if (cfg_valid && cfg_ready)
            mode_reg <= mode_t'(cfg_data);
    end

    // Byte update: next running hash, count and first char
    msh_update u_update (
        .mode       (mode_reg),
        .state      (state_reg),
        .data_byte  (in_data.data_byte),
        .last_byte  (in_data.last_byte),
        .state_next (state_next),
        .hash_fin   (hash_fin)
    );

    // Whole input waits when the result pipe is full
    assign in_stall  = hash_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.running_hash <= '1;
            state_reg.byte_count   <= '0;
            state_reg.first_char   <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Final hash of a string goes to the bucket pipeline on its last byte
    msh_bucket #(
        .BUCKETS (BUCKETS)
    ) u_bucket (
        .clk        (clk),
        .rst_n      (rst_n),
        .hash_valid (in_valid && in_data.last_byte),
        .hash_in    (hash_fin),
        .hash_stall (hash_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== hdl/msh_update.sv =====
// ----------------------------------------------------------------------------
// msh_update: per-byte hash update
// Combinational next state and final hash for one byte in the selected mode.
// ----------------------------------------------------------------------------
module msh_update (
    input  msh_pkg::mode_t                 mode,
    input  msh_pkg::msh_state_t            state,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    output msh_pkg::msh_state_t            state_next,
    output logic [msh_pkg::HASH_W-1:0]     hash_fin
);
    import msh_pkg::*;

    localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
    localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;
    localparam logic [31:0] DJB_START   = 32'd5381;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b,
                                             input logic [31:0] poly);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    logic        start;
    logic [31:0] base;
    logic [7:0]  first;
    logic [31:0] hash_new;

    assign start = (state.byte_count == 32'd0);
    assign first = start ? data_byte : state.first_char;

    always_comb
    begin
        if (!start)
            base = state.running_hash;
        else if (mode == MODE_DJB2)
            base = DJB_START;
        else if (mode == MODE_CRC32)
            base = ALL_ONES;
        else
            base = 32'd0;
    end

    always_comb
    begin
        unique case (mode)
            MODE_ZERO:   hash_new = 32'd0;
            MODE_LENGTH: hash_new = state.byte_count + 32'd1;
            MODE_FIRST:  hash_new = {24'd0, first};
            MODE_SUM:    hash_new = base + {24'd0, data_byte};
            MODE_DJB2:   hash_new = (base << 5) + base + {24'd0, data_byte};
            MODE_ROTXOR:
            begin
                // nibble swap of the first byte, xor the second, ignore the rest
                if (start)
                    hash_new = {24'd0, data_byte[3:0], data_byte[7:4]};
                else if (state.byte_count == 32'd1)
                    hash_new = base ^ {24'd0, data_byte};
                else
                    hash_new = base;
            end
            MODE_CRC32:  hash_new = crc_byte(base, data_byte, CRC32_POLY);
            MODE_CRC32C: hash_new = crc_byte(base, data_byte, CRC32C_POLY);
        endcase
    end

    assign state_next.running_hash = hash_new;
    assign state_next.first_char   = first;
    assign state_next.byte_count   = last_byte ? 32'd0 : state.byte_count + 32'd1;

    assign hash_fin = (mode == MODE_CRC32) ? ~hash_new : hash_new;

endmodule

// ===== hdl/msh_bucket.sv =====
// ----------------------------------------------------------------------------
// msh_bucket: bucket index pipeline and result register
// Three stages: hash register, reciprocal product, remainder and output.
// ----------------------------------------------------------------------------
module msh_bucket #(
    parameter int BUCKETS = msh_pkg::BUCKETS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hash_valid,
    input  logic [msh_pkg::HASH_W-1:0]  hash_in,
    output logic                        hash_stall,
    output logic                        out_valid,
    input  logic                        out_stall,
    output msh_pkg::out_item_t          out_data
);
    import msh_pkg::*;

    // q = floor(h * RECIP / 2^SHIFT) is exact or one short, so r < 2*BUCKETS
    localparam int          LOG_B      = $clog2(BUCKETS);
    localparam int          SHIFT      = 32 + LOG_B;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(BUCKETS);
    localparam logic [32:0] RECIP      = RECIP_FULL[32:0];
    localparam logic [31:0] DIVISOR    = 32'(BUCKETS);

    logic                v1_reg, v2_reg, v3_reg;
    logic [HASH_W-1:0]   h1_reg, h2_reg;
    logic [64:0]         p2_reg;
    out_item_t           out_reg;
    logic                rdy1, rdy2, rdy3;

    logic [64:0]         p_next;
    logic [31:0]         quot;
    logic [31:0]         qb_full;
    logic [31:0]         rem_raw;
    logic [31:0]         rem_fix;

    assign rdy3 = !v3_reg || !out_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign hash_stall = !rdy1;

    assign p_next  = {33'd0, h1_reg} * {32'd0, RECIP};
    assign quot    = 32'(p2_reg >> SHIFT);
    // only the low 32 bits of q*B matter for the remainder
    assign qb_full = quot * DIVISOR;
    assign rem_raw = h2_reg - qb_full;
    assign rem_fix = (rem_raw >= DIVISOR) ? rem_raw - DIVISOR : rem_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= hash_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && hash_valid)
            h1_reg <= hash_in;
        if (rdy2 && v1_reg)
        begin
            h2_reg <= h1_reg;
            p2_reg <= p_next;
        end
        if (rdy3 && v2_reg)
        begin
            out_reg.hash_value   <= h2_reg;
            out_reg.bucket_index <= rem_fix[BUCKET_W-1:0];
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/msh_checker.sv =====
// ----------------------------------------------------------------------------
// msh_checker: port-level checks for the multi-mode string hash
// Bound to the top level; watches its ports only.
// ----------------------------------------------------------------------------
module msh_checker #(
    parameter int BUCKETS = msh_pkg::BUCKETS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  msh_pkg::in_item_t   in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  msh_pkg::out_item_t  out_data
);
    import msh_pkg::*;

    localparam logic [BUCKET_W:0] LIMIT = (BUCKETS < 1024) ? (BUCKET_W+1)'(BUCKETS)
                                                           : (BUCKET_W+1)'(1024);

    // stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // stalled byte transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("byte changed while stalled");

    // input backs up only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    // remainder stays below the bucket count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, out_data.bucket_index} < LIMIT)
        else $error("bucket index out of range");

endmodule

bind multi_mode_string_hash msh_checker #(.BUCKETS(BUCKETS)) u_msh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/sv/multi_mode_string_hash_tb.sv =====
// ----------------------------------------------------------------------------
// multi_mode_string_hash_tb: self-checking bench for the string hasher
// Feeds byte strings under every hash mode with random gaps and output
// back-pressure. Expected hash and bucket values are computed alongside
// and compared with each result transaction.
// ----------------------------------------------------------------------------
module multi_mode_string_hash_tb;

    import msh_pkg::*;

    localparam int          BUCKETS      = BUCKETS_DEFAULT;
    localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC32C_POLY  = 32'h82F63B78;
    localparam logic [31:0] ALL_ONES     = 32'hFFFFFFFF;
    localparam logic [31:0] DJB_SEED     = 32'd5381;
    localparam logic [31:0] DJB_MUL      = 32'd33;
    // Extra settle once every expected result is in.
    localparam int          SETTLE       = 8;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          BURST_LEN    = 40;
    localparam int          TARGET_ITEMS = 1000;

    // What the driver works through: byte transactions, mode writes, and
    // drain points where it waits for the block to go quiet.
    typedef enum int {ENT_BYTE, ENT_MODE, ENT_DRAIN} entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        in_item_t    item;
        mode_t       mode;
        int          gap;
    } stim_entry_t;

    typedef enum int {DRV_FETCH, DRV_GAP, DRV_OFFER, DRV_CFG, DRV_DRAIN} drv_state_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0] cfg_data = '0;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    stim_entry_t byte_feed[$];      // stimulus not yet handed to the DUT
    out_item_t   hash_expected[$];  // predicted results, oldest first

    int error_count     = 0;
    int rx_count        = 0;        // result transactions taken so far
    int results_planned = 0;        // last bytes queued by the generator
    int items_planned   = 0;
    int burst_mark      = 32'h7FFFFFFF;

    // Handshake flags captured at the rising edge, used at the falling edge
    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;
    logic out_taken = 1'b0;

    // Predictor copy of the hasher
    mode_t       model_mode = MODE_RESET;
    logic [31:0] str_hash   = ALL_ONES;
    logic [31:0] str_len    = '0;
    logic [7:0]  str_first  = '0;

    // Driver bookkeeping
    drv_state_t  drv_st      = DRV_FETCH;
    stim_entry_t cur;
    int          gap_left    = 0;
    int          settle_left = 0;

    // Receiver bookkeeping
    int   wait_left = 0;
    logic hold_on   = 1'b0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    multi_mode_string_hash #(
        .BUCKETS   (BUCKETS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b,
                                               logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        return c;
    endfunction

    // Fold one accepted byte into the running string; on the last byte,
    // queue the hash and bucket the block should produce.
    task automatic absorb_byte(input in_item_t it);
        logic [31:0] h;
        out_item_t   r;
        // A fresh string starts from the seed of the mode in force now
        if (str_len == 0)
        begin
            case (model_mode)
                MODE_DJB2:  str_hash = DJB_SEED;
                MODE_CRC32: str_hash = ALL_ONES;
                default:    str_hash = '0;
            endcase
            str_first = it.data_byte;
        end
        // Each byte applies the mode selected at that byte, even mid-string
        case (model_mode)
            MODE_ZERO:   str_hash = '0;
            MODE_LENGTH: str_hash = str_len + 32'd1;
            MODE_FIRST:  str_hash = {24'd0, str_first};
            MODE_SUM:    str_hash = str_hash + {24'd0, it.data_byte};
            MODE_DJB2:   str_hash = str_hash * DJB_MUL + {24'd0, it.data_byte};
            MODE_ROTXOR:
            begin
                // nibble-swapped first byte, XOR second byte, rest ignored
                if (str_len == 0)
                    str_hash = {24'd0, it.data_byte[3:0], it.data_byte[7:4]};
                else if (str_len == 1)
                    str_hash = str_hash ^ {24'd0, it.data_byte};
            end
            MODE_CRC32:  str_hash = crc_update(str_hash, it.data_byte, CRC32_POLY);
            default:     str_hash = crc_update(str_hash, it.data_byte, CRC32C_POLY);
        endcase
        str_len = str_len + 32'd1;
        if (it.last_byte)
        begin
            // output rule follows the mode on the last byte
            h = (model_mode == MODE_CRC32) ? ~str_hash : str_hash;
            r.hash_value   = h;
            r.bucket_index = BUCKET_W'(h % 32'(BUCKETS));
            hash_expected.push_back(r);
            str_len = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples every handshake at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= in_valid && !in_stall;
            cfg_taken <= cfg_valid && cfg_ready;
            out_taken <= out_valid && !out_stall;
            // a byte taken at the same edge as a mode write still sees the old mode
            if (in_valid && !in_stall)
                absorb_byte(in_data);
            if (cfg_valid && cfg_ready)
                model_mode = mode_t'(cfg_data);
            if (out_valid && !out_stall)
            begin
                rx_count <= rx_count + 1;
                if (hash_expected.size() == 0)
                    report_mismatch("result with nothing expected", out_data.hash_value, '0);
                else
                begin
                    want = hash_expected.pop_front();
                    if (out_data.hash_value !== want.hash_value)
                        report_mismatch("hash_value", out_data.hash_value, want.hash_value);
                    if (out_data.bucket_index !== want.bucket_index)
                        report_mismatch("bucket_index", {22'd0, out_data.bucket_index},
                                        {22'd0, want.bucket_index});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: works through byte_feed at the falling edge. Each signal
    // gets a single nonblocking update per edge so a valid that stays up
    // for back-to-back transactions never glitches.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        logic     nxt_valid;
        in_item_t nxt_data;
        logic     nxt_cfg;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            nxt_cfg   = cfg_valid;
            if (drv_st == DRV_OFFER && in_taken)
            begin
                nxt_valid = 1'b0;
                drv_st    = DRV_FETCH;
            end
            if (drv_st == DRV_CFG && cfg_taken)
            begin
                nxt_cfg = 1'b0;
                drv_st  = DRV_FETCH;
            end
            // Drain: every result in, then let the pipeline settle
            if (drv_st == DRV_DRAIN && hash_expected.size() == 0)
            begin
                if (settle_left == 0)
                    drv_st = DRV_FETCH;
                else
                    settle_left--;
            end
            if (drv_st == DRV_GAP)
            begin
                if (gap_left == 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_data  = cur.item;
                    drv_st    = DRV_OFFER;
                end
                else
                    gap_left--;
            end
            if (drv_st == DRV_FETCH && byte_feed.size() != 0)
            begin
                cur = byte_feed.pop_front();
                case (cur.kind)
                    ENT_BYTE:
                    begin
                        if (cur.gap == 0)
                        begin
                            nxt_valid = 1'b1;
                            nxt_data  = cur.item;
                            drv_st    = DRV_OFFER;
                        end
                        else
                        begin
                            gap_left = cur.gap - 1;
                            drv_st   = DRV_GAP;
                        end
                    end
                    ENT_MODE:
                    begin
                        nxt_cfg  = 1'b1;
                        cfg_data <= cur.mode;
                        drv_st   = DRV_CFG;
                    end
                    default:
                    begin
                        settle_left = SETTLE;
                        drv_st      = DRV_DRAIN;
                    end
                endcase
            end
            in_valid  <= nxt_valid;
            in_data   <= nxt_data;
            cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here in its own process. It starts
    // a few results into the burst so the block backs up into in_stall.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && !hold_done && rx_count >= burst_mark)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        hold_on <= (hold_left > 0);
        if (hold_left > 0)
            hold_left--;
    end

    // Receiver: a random stall after each result, none in
    // every third block of results so there are stretches at full rate.
    always @(negedge clk)
    begin : receiver
        logic st;
        if (rst_n)
        begin
            if (out_taken)
                wait_left = ((rx_count / 128) % 3 == 1) ? 0 : $urandom_range(0, 4);
            st = 1'b0;
            if (wait_left > 0)
            begin
                st = 1'b1;
                wait_left--;
            end
            out_stall <= st || hold_on;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
        stim_entry_t e;
        e.kind           = ENT_BYTE;
        e.item.data_byte = b;
        e.item.last_byte = last;
        e.mode           = MODE_ZERO;
        e.gap            = gap;
        byte_feed.push_back(e);
        items_planned++;
        if (last)
            results_planned++;
    endtask

    task automatic push_drain();
        stim_entry_t e;
        e.kind = ENT_DRAIN;
        e.item = '0;
        e.mode = MODE_ZERO;
        e.gap  = 0;
        byte_feed.push_back(e);
    endtask

    // Mode writes only go out once the block is quiet
    task automatic push_mode(input mode_t m);
        stim_entry_t e;
        push_drain();
        e.kind = ENT_MODE;
        e.item = '0;
        e.mode = m;
        e.gap  = 0;
        byte_feed.push_back(e);
    endtask

    // Random string; optionally switches mode before byte switch_at
    task automatic push_string(input int len, input bit calm, input int switch_at);
        for (int i = 0; i < len; i++)
        begin
            if (i == switch_at)
                push_mode(mode_t'($urandom_range(0, 7)));
            push_byte($urandom_range(0, 255), (i == len - 1), calm ? 0 : $urandom_range(0, 4));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        int  pick;
        int  len;
        int  nstr;
        bit  calm;
        bit  burst_done;
        int  w;

        // Directed: reset mode (CRC-32) first, with no write yet
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'h00, 1'b1, 1);
        push_byte(8'h80, 1'b1, 0);
        push_mode(MODE_ZERO);
        push_byte(8'hFF, 1'b1, 2);
        push_mode(MODE_CRC32C);
        push_byte(8'h00, 1'b0, 0);
        push_byte(8'hFF, 1'b1, 0);
        // rotate-xor: single byte, then three bytes where the third is ignored
        push_mode(MODE_ROTXOR);
        push_byte(8'hA5, 1'b1, 0);
        push_byte(8'h12, 1'b0, 0);
        push_byte(8'h34, 1'b0, 3);
        push_byte(8'h56, 1'b1, 0);
        push_mode(MODE_DJB2);
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'hFF, 1'b1, 0);
        // Mode change mid-string: string starts under sum, ends under djb2
        push_mode(MODE_SUM);
        push_byte(8'hFF, 1'b0, 0);
        push_mode(MODE_DJB2);
        push_byte(8'h01, 1'b1, 0);
        push_mode(MODE_LENGTH);
        push_byte(8'h00, 1'b0, 0);
        push_byte(8'h55, 1'b0, 4);
        push_byte(8'hAA, 1'b1, 0);
        push_mode(MODE_FIRST);
        push_byte(8'h7F, 1'b0, 0);
        push_byte(8'h80, 1'b1, 0);

        // Random phases: one mode per phase apart from mid-string switches, mostly short strings
        burst_done = 1'b0;
        while (items_planned < TARGET_ITEMS)
        begin
            if (!burst_done && items_planned > 400)
            begin
                // Back-to-back single-byte strings while the receiver holds off
                push_drain();
                burst_mark = results_planned + 3;
                for (int i = 0; i < BURST_LEN; i++)
                    push_byte($urandom_range(0, 255), 1'b1, 0);
                burst_done = 1'b1;
            end
            push_mode(mode_t'($urandom_range(0, 7)));
            calm = ($urandom_range(0, 3) == 0);
            nstr = $urandom_range(2, 10);
            for (int s = 0; s < nstr; s++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    len = $urandom_range(1, 6);
                else if (pick < 95)
                    len = $urandom_range(7, 20);
                else
                    len = $urandom_range(21, 64);
                if (len > 1 && $urandom_range(0, 7) == 0)
                    push_string(len, calm, $urandom_range(1, len - 1));
                else
                    push_string(len, calm, -1);
            end
        end
        // Finish back in the reset mode so every phase boundary is drained
        push_mode(MODE_RESET);
        push_string(9, 1'b0, -1);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // All stimulus handed over and taken
        while (byte_feed.size() != 0 || drv_st != DRV_FETCH)
            @(posedge clk);
        // Outstanding results, with a bound so leftovers get reported
        for (w = 0; w < 2000 && hash_expected.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (hash_expected.size() != 0)
            report_mismatch("results never arrived", hash_expected.size(), 0);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/msh_pkg.sv
hdl/msh_update.sv
hdl/msh_bucket.sv
hdl/multi_mode_string_hash.sv
hdl/msh_checker.sv
tb/sv/multi_mode_string_hash_tb.sv
